// File: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared types and constants for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int BYTE_W      = 8;
   localparam int SBOX_DEPTH  = 256;
   localparam int SBOX_ADDR_W = 8;
   localparam int KEY_WORDS   = 4;
   localparam int WORD_W      = 32;
   localparam int KEY_MAX     = 16;
   localparam int KEY_IDX_W   = 4;
   localparam int CSR_IDX_W   = 8;

   localparam logic [SBOX_ADDR_W-1:0] SBOX_LAST = SBOX_ADDR_W'(SBOX_DEPTH - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3 = 8'd3;

   typedef logic [KEY_MAX-1:0][BYTE_W-1:0]  key_type;
   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_words_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_RD_K,
      ST_OUT
   } state_type;

endpackage

// File: rtl/rc4_stream_cipher.sv
// An accepted data beat reads S[i] and S[j], writes the swap back and reads S[k], five
// accesses to the single-port S-box RAM; no new beat is taken until its result is in the output register.
// A restart beat, or the first beat after reset, first runs the key schedule
// (a fill of all 256 entries, 4 RAM accesses for each of 256 swap steps, one first-entry read).
// Reset clears the key registers, both indices and the keyed flag; the S-box is
// rebuilt by the schedule and is never read before that.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// XORs each data byte with the next RC4 keystream byte; keys from four CSR words.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
   parameter int KEY_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_in
   input  logic [0:0]                    req_tuser,   // [0] restart
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] data_out
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rc4_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rc4_pkg::WORD_W-1:0]    csr_data
);

   import rc4_pkg::*;

   key_words_type     key_word_ff, key_word_in;
   key_type           key;
   result_type        res;
   logic              out_ready;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;
   assign key       = key_type'(key_word_ff);

   always_comb begin
      key_word_in = key_word_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_word_in[0] = csr_data;
            CSR_KEY_WORD_1: key_word_in[1] = csr_data;
            CSR_KEY_WORD_2: key_word_in[2] = csr_data;
            CSR_KEY_WORD_3: key_word_in[3] = csr_data;
            default:        key_word_in    = key_word_ff;
         endcase
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;

   rc4_engine #(
      .KEY_BYTES (KEY_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_data    (req_tdata),
      .req_restart (req_tuser[0]),
      .key         (key),
      .out_ready   (out_ready),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_word_ff  <= key_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 RAM
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/rc4_engine.sv
// ----------------------------------------------------------------------------
// RC4 engine
// Key schedule and keystream sequencer around the single-port S-box RAM.
// ----------------------------------------------------------------------------
module rc4_engine #(
   parameter int KEY_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data,
   input  logic                 req_restart,
   input  rc4_pkg::key_type     key,
   input  logic                 out_ready,
   output rc4_pkg::result_type  res
);

   import rc4_pkg::*;

   localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(KEY_BYTES - 1);

   state_type state_ff, state_in;

   logic [SBOX_ADDR_W-1:0] i_ff, i_in;
   logic [SBOX_ADDR_W-1:0] j_ff, j_in;
   logic [SBOX_ADDR_W-1:0] n_ff, n_in;
   logic [SBOX_ADDR_W-1:0] k_ff, k_in;
   logic [KEY_IDX_W-1:0]   kidx_ff, kidx_in;
   logic [BYTE_W-1:0]      si_ff, si_in;
   logic [BYTE_W-1:0]      data_ff, data_in;
   logic                   keyed_ff, keyed_in;

   logic                   ram_en;
   logic                   ram_we;
   logic [SBOX_ADDR_W-1:0] ram_addr;
   logic [BYTE_W-1:0]      ram_wdata;
   logic [BYTE_W-1:0]      ram_rdata;

   logic [SBOX_ADDR_W-1:0] j_sched;
   logic [SBOX_ADDR_W-1:0] j_prga;
   logic [SBOX_ADDR_W-1:0] i_next;

   assign j_sched = j_ff + ram_rdata + key[kidx_ff];
   assign j_prga  = j_ff + ram_rdata;
   assign i_next  = i_ff + 8'd1;

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SBOX_DEPTH)
   ) u_sbox (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_restart || !keyed_ff) ? ST_FILL : ST_RD_J;
            end
         end
         ST_FILL:    state_in = (n_ff == SBOX_LAST) ? ST_KS_RD_I : ST_FILL;
         ST_KS_RD_I: state_in = ST_KS_RD_J;
         ST_KS_RD_J: state_in = ST_KS_WR_I;
         ST_KS_WR_I: state_in = ST_KS_WR_J;
         ST_KS_WR_J: state_in = (n_ff == SBOX_LAST) ? ST_RD_I : ST_KS_RD_I;
         ST_RD_I:    state_in = ST_RD_J;
         ST_RD_J:    state_in = ST_WR_I;
         ST_WR_I:    state_in = ST_WR_J;
         ST_WR_J:    state_in = ST_RD_K;
         ST_RD_K:    state_in = ST_OUT;
         ST_OUT:     state_in = out_ready ? ST_IDLE : ST_OUT;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      res.valid  = 1'b0;
      res.data   = ram_rdata ^ data_ff;
      ram_en     = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = i_ff;
      ram_wdata  = si_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      kidx_in    = kidx_ff;
      si_in      = si_ff;
      data_in    = data_ff;
      keyed_in   = keyed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               data_in = req_data;
               if (req_restart || !keyed_ff) begin
                  n_in = '0;
               end else begin
                  ram_en   = 1'b1;
                  ram_addr = i_next;
                  i_in     = i_next;
               end
            end
         end
         ST_FILL: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = n_ff;
            ram_wdata = n_ff;
            n_in      = n_ff + 8'd1;
            j_in      = '0;
            kidx_in   = '0;
         end
         ST_KS_RD_I: begin
            ram_en   = 1'b1;
            ram_addr = n_ff;
         end
         ST_KS_RD_J: begin
            si_in    = ram_rdata;
            j_in     = j_sched;
            ram_en   = 1'b1;
            ram_addr = j_sched;
         end
         ST_KS_WR_I: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = n_ff;
            ram_wdata = ram_rdata;
         end
         ST_KS_WR_J: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = j_ff;
            ram_wdata = si_ff;
            n_in      = n_ff + 8'd1;
            kidx_in   = (kidx_ff == KEY_LAST) ? '0 : kidx_ff + 4'd1;
            if (n_ff == SBOX_LAST) begin
               i_in     = '0;
               j_in     = '0;
               keyed_in = 1'b1;
            end
         end
         ST_RD_I: begin
            ram_en   = 1'b1;
            ram_addr = i_next;
            i_in     = i_next;
         end
         ST_RD_J: begin
            si_in    = ram_rdata;
            j_in     = j_prga;
            ram_en   = 1'b1;
            ram_addr = j_prga;
         end
         ST_WR_I: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = i_ff;
            ram_wdata = ram_rdata;
            k_in      = si_ff + ram_rdata;
         end
         ST_WR_J: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = j_ff;
            ram_wdata = si_ff;
         end
         ST_RD_K: begin
            ram_en   = 1'b1;
            ram_addr = k_ff;
         end
         ST_OUT: begin
            res.valid = out_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         keyed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         keyed_ff <= keyed_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      k_ff    <= k_in;
      kidx_ff <= kidx_in;
      si_ff   <= si_in;
      data_ff <= data_in;
   end

   a_keyed_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(keyed_ff))
      else $error("keyed flag dropped after a key schedule");

   a_prga_starts_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_I) |-> (i_ff == '0 && j_ff == '0))
      else $error("indices not cleared at end of key schedule");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !res.valid)
      else $error("result produced right after accepting a beat");

   a_result_only_when_free: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (out_ready && state_ff == ST_OUT))
      else $error("result issued while output register is busy");

endmodule
